[hw/rtl/rbc_pkg.sv]
`timescale 1ns / 1ps

package rbc_pkg;

  localparam int unsigned ATTEMPT_LIMIT = 1024;
  localparam int unsigned ATTEMPT_W     = 11;
  localparam int unsigned LIMIT_CMP_W   = 17;
  localparam int unsigned BACKOFF_W     = 32;
  localparam int unsigned CLASS_W       = 3;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned REG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST  = 11'd4;
  localparam logic [BACKOFF_W-1:0] FIRST_BACKOFF_RST = 32'd100;
  localparam logic [BACKOFF_W-1:0] BACKOFF_CAP_RST   = 32'd10000;

  localparam logic [CLASS_W-1:0] CLS_OK          = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_UNAVAILABLE = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_IO_ERROR    = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_EXHAUSTED   = 3'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_BEGIN = 2'd0,
    FN_ACK   = 2'd1,
    FN_FAIL  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ACTIVE  = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_DONE    = 3'd3,
    PH_FAILED  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TERMINAL   = 3'd1,
    ST_ACTIVE     = 3'd2,
    ST_IN_BACKOFF = 3'd3,
    ST_BUDGET_OUT = 3'd4,
    ST_NO_ATTEMPT = 3'd5,
    ST_FAILURE_OK = 3'd6,
    ST_BAD_LIMITS = 3'd7
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_ATTEMPTS  = 2'd0,
    REG_FIRST_BACKOFF = 2'd1,
    REG_BACKOFF_CAP   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ATTEMPT_W-1:0] max_attempts;
    logic [BACKOFF_W-1:0] first_backoff;
    logic [BACKOFF_W-1:0] backoff_cap;
  } cfg_t;

  typedef struct packed {
    logic                 vld;
    logic [BACKOFF_W-1:0] value;
  } bo_load_t;

endpackage

[hw/rtl/rbc_cfg_regs.sv]
`timescale 1ns / 1ps

module rbc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbc_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output rbc_pkg::cfg_t                      cfg_o,
  output rbc_pkg::bo_load_t                  ld_o
);

  rbc_pkg::cfg_t cfg_q, cfg_d;
  logic          ld_first;

  always_comb begin
    cfg_d    = cfg_q;
    ld_first = 1'b0;
    if (cfg_we_i) begin
      unique case (rbc_pkg::reg_idx_e'(cfg_idx_i))
        rbc_pkg::REG_MAX_ATTEMPTS: begin
          cfg_d.max_attempts = cfg_data_i[rbc_pkg::ATTEMPT_W-1:0];
        end
        rbc_pkg::REG_FIRST_BACKOFF: begin
          cfg_d.first_backoff = cfg_data_i[rbc_pkg::BACKOFF_W-1:0];
          ld_first            = 1'b1;
        end
        rbc_pkg::REG_BACKOFF_CAP: begin
          cfg_d.backoff_cap = cfg_data_i[rbc_pkg::BACKOFF_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts  <= rbc_pkg::MAX_ATTEMPTS_RST;
      cfg_q.first_backoff <= rbc_pkg::FIRST_BACKOFF_RST;
      cfg_q.backoff_cap   <= rbc_pkg::BACKOFF_CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign ld_o.vld   = ld_first;
  assign ld_o.value = cfg_data_i[rbc_pkg::BACKOFF_W-1:0];

endmodule

[hw/rtl/rbc_in_stage.sv]
`timescale 1ns / 1ps

module rbc_in_stage #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [rbc_pkg::FUNC_W-1:0]     s_func_i,
  input  logic [TIME_BITS-1:0]           s_now_i,
  input  logic [rbc_pkg::CLASS_W-1:0]    s_class_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output rbc_pkg::func_e                 func_o,
  output logic [TIME_BITS-1:0]           now_o,
  output logic [rbc_pkg::CLASS_W-1:0]    class_o
);

  logic                        vld_q;
  rbc_pkg::func_e              func_q;
  logic [TIME_BITS-1:0]        now_q;
  logic [rbc_pkg::CLASS_W-1:0] class_q;

  assign s_ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      func_q  <= rbc_pkg::func_e'(s_func_i);
      now_q   <= s_now_i;
      class_q <= s_class_i;
    end
  end

  assign valid_o = vld_q;
  assign func_o  = func_q;
  assign now_o   = now_q;
  assign class_o = class_q;

endmodule

[hw/rtl/rbc_core.sv]
`timescale 1ns / 1ps

module rbc_core #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rbc_pkg::cfg_t                     cfg_i,
  input  rbc_pkg::bo_load_t                 ld_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rbc_pkg::func_e                    in_func_i,
  input  logic [TIME_BITS-1:0]              in_now_i,
  input  logic [rbc_pkg::CLASS_W-1:0]       in_class_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rbc_pkg::status_e                  status_o,
  output rbc_pkg::phase_e                   phase_o,
  output logic [rbc_pkg::ATTEMPT_W-1:0]     attempt_o,
  output logic [TIME_BITS-1:0]              nb_ms_o,
  output logic                              nb_valid_o,
  output logic [rbc_pkg::CLASS_W-1:0]       last_class_o,
  output logic                              last_valid_o
);

  localparam int unsigned SUM_W = ((TIME_BITS > rbc_pkg::BACKOFF_W) ?
                                   TIME_BITS : rbc_pkg::BACKOFF_W) + 1;

  rbc_pkg::phase_e                 phase_q, phase_d;
  logic [rbc_pkg::ATTEMPT_W-1:0]   count_q, count_d;
  logic [rbc_pkg::BACKOFF_W-1:0]   cb_q, cb_d;
  logic [TIME_BITS-1:0]            dl_q, dl_d;
  logic                            dlv_q, dlv_d;
  logic [rbc_pkg::CLASS_W-1:0]     last_q, last_d;
  logic                            lv_q, lv_d;

  logic                            out_vld_q;
  rbc_pkg::status_e                status_q, status_d;
  rbc_pkg::phase_e                 ophase_q;
  logic [rbc_pkg::ATTEMPT_W-1:0]   ocount_q;
  logic [TIME_BITS-1:0]            odl_q;
  logic                            odlv_q;
  logic [rbc_pkg::CLASS_W-1:0]     olast_q;
  logic                            olv_q;

  logic                            fire;
  logic                            limits_ok;
  logic                            budget_out;
  logic                            retryable;
  logic [SUM_W-1:0]                dl_sum;
  logic [TIME_BITS-1:0]            dl_sat;
  logic [rbc_pkg::BACKOFF_W:0]     cb_dbl;
  logic [rbc_pkg::BACKOFF_W-1:0]   cb_next;

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign limits_ok = (cfg_i.max_attempts != '0) &&
                     (rbc_pkg::LIMIT_CMP_W'(cfg_i.max_attempts) <=
                      rbc_pkg::LIMIT_CMP_W'(rbc_pkg::ATTEMPT_LIMIT)) &&
                     (cfg_i.first_backoff != '0) &&
                     (cfg_i.backoff_cap >= cfg_i.first_backoff);
  assign budget_out = count_q >= cfg_i.max_attempts;
  assign retryable  = (in_class_i == rbc_pkg::CLS_UNAVAILABLE) ||
                      (in_class_i == rbc_pkg::CLS_IO_ERROR) ||
                      (in_class_i == rbc_pkg::CLS_EXHAUSTED);

  assign dl_sum = SUM_W'(in_now_i) + SUM_W'(cb_q);
  assign dl_sat = (|dl_sum[SUM_W-1:TIME_BITS]) ? '1 : dl_sum[TIME_BITS-1:0];

  assign cb_dbl  = {cb_q, 1'b0};
  assign cb_next = (cb_q >= cfg_i.backoff_cap) ? cb_q :
                   (cb_dbl < {1'b0, cfg_i.backoff_cap}) ?
                   cb_dbl[rbc_pkg::BACKOFF_W-1:0] : cfg_i.backoff_cap;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    cb_d     = cb_q;
    dl_d     = dl_q;
    dlv_d    = dlv_q;
    last_d   = last_q;
    lv_d     = lv_q;
    status_d = rbc_pkg::ST_OK;
    if (fire) begin
      unique case (in_func_i)
        rbc_pkg::FN_BEGIN: begin
          if (!limits_ok) begin
            status_d = rbc_pkg::ST_BAD_LIMITS;
          end else if (phase_q inside {rbc_pkg::PH_DONE, rbc_pkg::PH_FAILED}) begin
            status_d = rbc_pkg::ST_TERMINAL;
          end else if (phase_q == rbc_pkg::PH_ACTIVE) begin
            status_d = rbc_pkg::ST_ACTIVE;
          end else if (phase_q == rbc_pkg::PH_BACKOFF && in_now_i < dl_q) begin
            status_d = rbc_pkg::ST_IN_BACKOFF;
          end else if (budget_out) begin
            status_d = rbc_pkg::ST_BUDGET_OUT;
          end else begin
            count_d = count_q + 1'b1;
            phase_d = rbc_pkg::PH_ACTIVE;
            dlv_d   = 1'b0;
          end
        end
        rbc_pkg::FN_ACK: begin
          if (phase_q != rbc_pkg::PH_ACTIVE) begin
            status_d = rbc_pkg::ST_NO_ATTEMPT;
          end else begin
            phase_d = rbc_pkg::PH_DONE;
            last_d  = rbc_pkg::CLS_OK;
            lv_d    = 1'b1;
            dlv_d   = 1'b0;
          end
        end
        rbc_pkg::FN_FAIL: begin
          if (phase_q != rbc_pkg::PH_ACTIVE) begin
            status_d = rbc_pkg::ST_NO_ATTEMPT;
          end else if (in_class_i == rbc_pkg::CLS_OK) begin
            status_d = rbc_pkg::ST_FAILURE_OK;
          end else begin
            last_d = in_class_i;
            lv_d   = 1'b1;
            if (!retryable || budget_out) begin
              phase_d = rbc_pkg::PH_FAILED;
              dlv_d   = 1'b0;
            end else begin
              phase_d = rbc_pkg::PH_BACKOFF;
              dl_d    = dl_sat;
              dlv_d   = 1'b1;
              cb_d    = cb_next;
            end
          end
        end
        default: begin
          status_d = rbc_pkg::ST_OK;
        end
      endcase
    end else if (ld_i.vld && phase_q == rbc_pkg::PH_IDLE && count_q == '0) begin
      cb_d = ld_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rbc_pkg::PH_IDLE;
      count_q   <= '0;
      cb_q      <= rbc_pkg::FIRST_BACKOFF_RST;
      dl_q      <= '0;
      dlv_q     <= 1'b0;
      last_q    <= rbc_pkg::CLS_OK;
      lv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      cb_q    <= cb_d;
      dl_q    <= dl_d;
      dlv_q   <= dlv_d;
      last_q  <= last_d;
      lv_q    <= lv_d;
      if (in_ready_o) begin
        out_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      ophase_q <= phase_d;
      ocount_q <= count_d;
      odl_q    <= dlv_d ? dl_d : '0;
      odlv_q   <= dlv_d;
      olast_q  <= lv_d ? last_d : rbc_pkg::CLS_OK;
      olv_q    <= lv_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = status_q;
  assign phase_o      = ophase_q;
  assign attempt_o    = ocount_q;
  assign nb_ms_o      = odl_q;
  assign nb_valid_o   = odlv_q;
  assign last_class_o = olast_q;
  assign last_valid_o = olv_q;

endmodule

[hw/rtl/retry_backoff_controller.sv]
`timescale 1ns / 1ps

// Retry controller with an attempt budget and capped exponential backoff. Each
// input word is one event (begin, acknowledged, failed, none) and produces exactly one
// result word with a status code and the controller state after the event. The
// block takes one event per clock cycle while the result port is not stalled. A result
// word is presented after its event has been captured in the input register and the state
// update has loaded the result register; a stall on the result port holds the event back.
// The rate is set by the state update loop, whose longest path is the saturating
// deadline add and the backoff doubling compare. Limits are written through the
// configuration port while no event is in flight; this binds the user, and the block
// itself does not enforce it. No initialization sweep is needed after reset.
module retry_backoff_controller #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [rbc_pkg::REG_IDX_W-1:0]           cfg_idx_i,
  input  logic [rbc_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // now_ms, failure_class
  input  logic [((TIME_BITS+3+7)/8)*8-1:0]        s_axis_tdata,
  // func
  input  logic [rbc_pkg::FUNC_W-1:0]              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // status, phase, attempt_cnt, not_before_ms, not_before_valid,
  // last_class, last_class_valid
  output logic [((TIME_BITS+22+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int unsigned OUT_W  = ((TIME_BITS + 22 + 7) / 8) * 8;
  localparam int unsigned PACK_W = TIME_BITS + 22;

  rbc_pkg::cfg_t                  cfg;
  rbc_pkg::bo_load_t              bo_ld;
  logic                           ev_valid;
  logic                           ev_ready;
  rbc_pkg::func_e                 ev_func;
  logic [TIME_BITS-1:0]           ev_now;
  logic [rbc_pkg::CLASS_W-1:0]    ev_class;
  rbc_pkg::status_e               r_status;
  rbc_pkg::phase_e                r_phase;
  logic [rbc_pkg::ATTEMPT_W-1:0]  r_attempt;
  logic [TIME_BITS-1:0]           r_nb_ms;
  logic                           r_nb_valid;
  logic [rbc_pkg::CLASS_W-1:0]    r_last_class;
  logic                           r_last_valid;
  logic [PACK_W-1:0]              r_packed;

  rbc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .ld_o       (bo_ld)
  );

  rbc_in_stage #(
    .TIME_BITS (TIME_BITS)
  ) u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_func_i  (s_axis_tuser),
    .s_now_i   (s_axis_tdata[TIME_BITS-1:0]),
    .s_class_i (s_axis_tdata[TIME_BITS+rbc_pkg::CLASS_W-1:TIME_BITS]),
    .valid_o   (ev_valid),
    .ready_i   (ev_ready),
    .func_o    (ev_func),
    .now_o     (ev_now),
    .class_o   (ev_class)
  );

  rbc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .ld_i         (bo_ld),
    .in_valid_i   (ev_valid),
    .in_ready_o   (ev_ready),
    .in_func_i    (ev_func),
    .in_now_i     (ev_now),
    .in_class_i   (ev_class),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (r_status),
    .phase_o      (r_phase),
    .attempt_o    (r_attempt),
    .nb_ms_o      (r_nb_ms),
    .nb_valid_o   (r_nb_valid),
    .last_class_o (r_last_class),
    .last_valid_o (r_last_valid)
  );

  assign r_packed = {r_last_valid, r_last_class, r_nb_valid, r_nb_ms,
                     r_attempt, r_phase, r_status};
  assign m_axis_tdata = OUT_W'(r_packed);

endmodule

[hw/rtl/rbc_checker.sv]
`timescale 1ns / 1ps

module rbc_checker #(
  parameter int unsigned TIME_BITS = 48
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((TIME_BITS+22+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned NB_LO = 17;
  localparam int unsigned NBV   = NB_LO + TIME_BITS;
  localparam int unsigned LC_LO = NBV + 1;
  localparam int unsigned LCV   = LC_LO + 3;

  logic [2:0]           o_status;
  logic [2:0]           o_phase;
  logic [TIME_BITS-1:0] o_nb;
  logic                 o_nbv;
  logic [2:0]           o_lc;
  logic                 o_lcv;

  assign o_status = m_axis_tdata[2:0];
  assign o_phase  = m_axis_tdata[5:3];
  assign o_nb     = m_axis_tdata[NBV-1:NB_LO];
  assign o_nbv    = m_axis_tdata[NBV];
  assign o_lc     = m_axis_tdata[LCV-1:LC_LO];
  assign o_lcv    = m_axis_tdata[LCV];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_backoff_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((o_phase == rbc_pkg::PH_BACKOFF) == o_nbv))
    else $error("deadline flag disagrees with backoff phase");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((o_nbv || o_nb == '0) && (o_lcv || o_lc == '0)))
    else $error("invalid field not zero");

  a_status_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((o_status != rbc_pkg::ST_ACTIVE &&
                        o_status != rbc_pkg::ST_FAILURE_OK) ||
                       o_phase == rbc_pkg::PH_ACTIVE))
    else $error("status requires an active attempt");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid && !m_axis_tready) &&
    $past(s_axis_tvalid && s_axis_tready) |-> !s_axis_tready)
    else $error("input accepted with both stages full");

endmodule

bind retry_backoff_controller rbc_checker #(
  .TIME_BITS (TIME_BITS)
) u_rbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
